@@ rtl/swk_pkg.sv @@
// Shared types, constants and CORDIC / divider step functions for the
// swerve wheel kinematics pipeline. Depends on nothing; all rtl files use it.
`default_nettype none

package swk_pkg;

  // Port and register widths.
  localparam int CMD_W      = 16;
  localparam int ANG_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DZ_W       = 15;
  localparam int RATIO_W    = 16;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd3;

  // Register values after reset.
  localparam logic [DZ_W-1:0]    DEADZONE_RST = 15'd3277;
  localparam logic [RATIO_W-1:0] LENGTH_RST   = 16'd46341;
  localparam logic [RATIO_W-1:0] WIDTH_RST    = 16'd46341;
  localparam logic [RATIO_W-1:0] SCALE_RST    = 16'd49152;

  // CORDIC organization: four iterations per register stage.
  localparam int CORDIC_ITERS    = 16;
  localparam int ITERS_PER_STAGE = 4;
  localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;

  // Internal datapath widths.
  localparam int ROT_W   = 24;  // rotation x/y with four guard bits
  localparam int VEC_W   = 26;  // vectoring x/y with four guard bits
  localparam int Z_W     = 25;  // angle accumulator, 1/256 centidegree
  localparam int WHEEL_W = 19;  // per-wheel strafe/forward parts
  localparam int MAG_W   = 17;  // unsigned wheel magnitude
  localparam int QUO_W   = 16;  // normalized speed

  // Divider organization: four restoring steps per register stage.
  localparam int DIV_STEPS           = 16;
  localparam int DIV_STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES          = DIV_STEPS / DIV_STEPS_PER_STAGE;

  localparam logic signed [Z_W-1:0] ANG_180_FX = 25'sd4608000;
  localparam logic signed [15:0]    INV_GAIN   = 16'sd19898;

  // Arctangent of 2^-i in 1/256 centidegree.
  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
    25'sd1152000, 25'sd680065, 25'sd359328, 25'sd182400,
    25'sd91554,   25'sd45822,  25'sd22916,  25'sd11459,
    25'sd5730,    25'sd2865,   25'sd1432,   25'sd716,
    25'sd358,     25'sd179,    25'sd90,     25'sd45
  };

  typedef struct packed {
    logic signed [ROT_W-1:0] cx;
    logic signed [ROT_W-1:0] cy;
    logic signed [Z_W-1:0]   z;
  } rot_vec_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [Z_W-1:0]   z;
    logic                    zero;
  } vec_t;

  typedef struct packed {
    logic [MAG_W:0]   r;
    logic [MAG_W-1:0] d;
    logic [QUO_W-1:0] q;
  } div_t;

  // One rotation-mode CORDIC iteration, driving z toward zero.
  function automatic rot_vec_t rot_iter(input rot_vec_t v, input int i);
    rot_vec_t o;
    logic signed [ROT_W-1:0] dx;
    logic signed [ROT_W-1:0] dy;
    o  = v;
    dx = v.cy >>> i;
    dy = v.cx >>> i;
    if (v.z >= 0) begin
      o.cx = v.cx - dx;
      o.cy = v.cy + dy;
      o.z  = v.z - ATAN_TAB[i[3:0]];
    end else begin
      o.cx = v.cx + dx;
      o.cy = v.cy - dy;
      o.z  = v.z + ATAN_TAB[i[3:0]];
    end
    return o;
  endfunction

  // One vectoring-mode CORDIC iteration, driving y toward zero.
  function automatic vec_t vec_iter(input vec_t v, input int i);
    vec_t o;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    o  = v;
    dx = v.y >>> i;
    dy = v.x >>> i;
    if (v.y >= 0) begin
      o.x = v.x + dx;
      o.y = v.y - dy;
      o.z = v.z + ATAN_TAB[i[3:0]];
    end else begin
      o.x = v.x - dx;
      o.y = v.y + dy;
      o.z = v.z - ATAN_TAB[i[3:0]];
    end
    return o;
  endfunction

  // One restoring division step; the first step takes the integer bit.
  function automatic div_t div_step(input div_t v, input logic first);
    div_t o;
    logic [MAG_W:0] r;
    logic           qb;
    o  = v;
    r  = first ? v.r : {v.r[MAG_W-1:0], 1'b0};
    qb = (r >= {1'b0, v.d});
    if (qb) begin
      r = r - {1'b0, v.d};
    end
    o.r = r;
    o.q = {v.q[QUO_W-2:0], qb};
    return o;
  endfunction

endpackage

`default_nettype wire

@@ rtl/swk_rot_cordic.sv @@
// Pipelined rotation-mode CORDIC used for the field-oriented heading turn.
// Depends on swk_pkg for the vector type and the iteration function.
`default_nettype none

module swk_rot_cordic (
  input  wire logic             clk,
  input  wire swk_pkg::rot_vec_t din,
  output swk_pkg::rot_vec_t     dout
);

  swk_pkg::rot_vec_t stg [swk_pkg::CORDIC_STAGES];

  // Each stage applies four iterations and registers the result.
  for (genvar s = 0; s < swk_pkg::CORDIC_STAGES; s++) begin : g_stage
    swk_pkg::rot_vec_t cur;
    swk_pkg::rot_vec_t nxt;

    if (s == 0) begin : g_first
      assign cur = din;
    end else begin : g_next
      assign cur = stg[s-1];
    end

    always_comb begin
      nxt = cur;
      for (int k = 0; k < swk_pkg::ITERS_PER_STAGE; k++) begin
        nxt = swk_pkg::rot_iter(nxt, s * swk_pkg::ITERS_PER_STAGE + k);
      end
    end

    always_ff @(posedge clk) begin
      stg[s] <= nxt;
    end
  end

  assign dout = stg[swk_pkg::CORDIC_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/swk_vec_cordic.sv @@
// Pipelined vectoring-mode CORDIC giving one wheel's angle and scaled length.
// Depends on swk_pkg for the vector type, constants and iteration function.
`default_nettype none

module swk_vec_cordic (
  input  wire logic                               clk,
  input  wire logic signed [swk_pkg::WHEEL_W-1:0] s_part,
  input  wire logic signed [swk_pkg::WHEEL_W-1:0] f_part,
  output swk_pkg::vec_t                           dout
);

  swk_pkg::vec_t pre;
  swk_pkg::vec_t pre_next;
  swk_pkg::vec_t stg [swk_pkg::CORDIC_STAGES];

  // Prescale and move the vector into the right half plane.
  always_comb begin
    pre_next.x    = swk_pkg::VEC_W'(f_part) <<< 4;
    pre_next.y    = swk_pkg::VEC_W'(s_part) <<< 4;
    pre_next.z    = '0;
    pre_next.zero = (s_part == '0) && (f_part == '0);
    if (f_part < 0) begin
      pre_next.x = -pre_next.x;
      pre_next.y = -pre_next.y;
      pre_next.z = (s_part >= 0) ? swk_pkg::ANG_180_FX : -swk_pkg::ANG_180_FX;
    end
  end

  always_ff @(posedge clk) begin
    pre <= pre_next;
  end

  // Iteration stages, four iterations each.
  for (genvar s = 0; s < swk_pkg::CORDIC_STAGES; s++) begin : g_stage
    swk_pkg::vec_t cur;
    swk_pkg::vec_t nxt;

    if (s == 0) begin : g_first
      assign cur = pre;
    end else begin : g_next
      assign cur = stg[s-1];
    end

    always_comb begin
      nxt = cur;
      for (int k = 0; k < swk_pkg::ITERS_PER_STAGE; k++) begin
        nxt = swk_pkg::vec_iter(nxt, s * swk_pkg::ITERS_PER_STAGE + k);
      end
    end

    always_ff @(posedge clk) begin
      stg[s] <= nxt;
    end
  end

  assign dout = stg[swk_pkg::CORDIC_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/swk_div.sv @@
// Pipelined restoring divider forming floor(num * 32768 / den) for num <= den.
// Depends on swk_pkg for the divider type and step function.
`default_nettype none

module swk_div (
  input  wire logic                       clk,
  input  wire logic [swk_pkg::MAG_W-1:0]  num,
  input  wire logic [swk_pkg::MAG_W-1:0]  den,
  output wire logic [swk_pkg::QUO_W-1:0]  quo
);

  swk_pkg::div_t stg [swk_pkg::DIV_STAGES];
  swk_pkg::div_t din;

  assign din.r = {1'b0, num};
  assign din.d = den;
  assign din.q = '0;

  // Each stage resolves four quotient bits, most significant first.
  for (genvar s = 0; s < swk_pkg::DIV_STAGES; s++) begin : g_stage
    swk_pkg::div_t cur;
    swk_pkg::div_t nxt;

    if (s == 0) begin : g_first
      assign cur = din;
    end else begin : g_next
      assign cur = stg[s-1];
    end

    always_comb begin
      nxt = cur;
      for (int k = 0; k < swk_pkg::DIV_STEPS_PER_STAGE; k++) begin
        nxt = swk_pkg::div_step(nxt, (s == 0) && (k == 0));
      end
    end

    always_ff @(posedge clk) begin
      stg[s] <= nxt;
    end
  end

  assign quo = stg[swk_pkg::DIV_STAGES-1].q;

endmodule

`default_nettype wire

@@ rtl/swerve_wheel_kinematics.sv @@
// Four-wheel swerve inverse kinematics: a fixed 22-stage pipeline that takes
// one command per clock and returns its wheel speeds and angles from the last
// register stage, strobed by done for one cycle. The latency is set by
// the heading rotation CORDIC (4 stages), the per-wheel vectoring CORDICs
// (5 stages) and the speed normalizing divider (4 stages) plus the
// surrounding multiply and fix-up stages. The result cannot be held off, so
// busy is high only while rst is applied. Configuration is taken while rst
// is low; write registers only while no command is in flight.
// Depends on swk_pkg, swk_rot_cordic, swk_vec_cordic and swk_div.
`default_nettype none

module swerve_wheel_kinematics (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output wire logic                                  busy,
  input  wire logic signed [swk_pkg::CMD_W-1:0]      strafe_cmd,
  input  wire logic signed [swk_pkg::CMD_W-1:0]      forward_cmd,
  input  wire logic signed [swk_pkg::CMD_W-1:0]      rotate_cmd,
  input  wire logic signed [swk_pkg::ANG_W-1:0]      heading,
  input  wire logic                                  mode,
  input  wire logic signed [swk_pkg::ANG_W-1:0]      fl_now_angle,
  input  wire logic signed [swk_pkg::ANG_W-1:0]      fr_now_angle,
  input  wire logic signed [swk_pkg::ANG_W-1:0]      bl_now_angle,
  input  wire logic signed [swk_pkg::ANG_W-1:0]      br_now_angle,
  input  wire logic                                  cfg_valid,
  output wire logic                                  cfg_ready,
  input  wire logic [swk_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [swk_pkg::CFG_DATA_W-1:0]        cfg_data,
  output wire logic                                  done,
  output logic signed [swk_pkg::CMD_W-1:0]           fl_drive,
  output logic signed [swk_pkg::CMD_W-1:0]           fr_drive,
  output logic signed [swk_pkg::CMD_W-1:0]           bl_drive,
  output logic signed [swk_pkg::CMD_W-1:0]           br_drive,
  output logic signed [swk_pkg::ANG_W-1:0]           fl_steer,
  output logic signed [swk_pkg::ANG_W-1:0]           fr_steer,
  output logic signed [swk_pkg::ANG_W-1:0]           bl_steer,
  output logic signed [swk_pkg::ANG_W-1:0]           br_steer
);

  localparam int PIPE_LEN   = 22;
  localparam int SIDE_DEPTH = 19;
  localparam int IDLE_DEPTH = 18;
  localparam int LANES      = 4;
  localparam int HD_W       = 18;
  localparam int DIFF_W     = 19;
  localparam int CMD_W      = swk_pkg::CMD_W;
  localparam int ANG_W      = swk_pkg::ANG_W;
  localparam int MAG_W      = swk_pkg::MAG_W;
  localparam int QUO_W      = swk_pkg::QUO_W;
  localparam int WHEEL_W    = swk_pkg::WHEEL_W;

  localparam logic signed [HD_W-1:0]   HD_FULL   = 18'sd36000;
  localparam logic signed [HD_W-1:0]   HD_HALF   = 18'sd18000;
  localparam logic signed [HD_W-1:0]   HD_QUART  = 18'sd9000;
  localparam logic signed [DIFF_W-1:0] DF_FULL   = 19'sd36000;
  localparam logic signed [DIFF_W-1:0] DF_TWO    = 19'sd72000;
  localparam logic signed [DIFF_W-1:0] DF_HALF   = 19'sd18000;
  localparam logic signed [DIFF_W-1:0] DF_QUART  = 19'sd9000;
  localparam logic signed [ANG_W-1:0]  ANG_HALF  = 17'sd18000;
  localparam logic [MAG_W-1:0]         MAG_ONE   = 17'd32768;

  typedef struct packed {
    logic signed [CMD_W-1:0]  x;
    logic signed [CMD_W-1:0]  y;
    logic                     mode;
    logic signed [ANG_W-1:0]  lr;
    logic signed [ANG_W-1:0]  wr;
    logic [LANES-1:0][ANG_W-1:0] now;
  } side_t;

  typedef struct packed {
    logic [LANES-1:0][MAG_W-1:0] mag;
    logic [LANES-1:0][ANG_W-1:0] ang;
    logic                        norm;
  } mid_t;

  // Configuration registers.
  logic [swk_pkg::DZ_W-1:0]    deadzone;
  logic [swk_pkg::RATIO_W-1:0] length_ratio;
  logic [swk_pkg::RATIO_W-1:0] width_ratio;
  logic [swk_pkg::RATIO_W-1:0] speed_scale;

  logic [PIPE_LEN-1:0] vld;
  logic                accept;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;
  assign done      = vld[PIPE_LEN-1];

  // Register writes on a completed configuration transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone     <= swk_pkg::DEADZONE_RST;
      length_ratio <= swk_pkg::LENGTH_RST;
      width_ratio  <= swk_pkg::WIDTH_RST;
      speed_scale  <= swk_pkg::SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swk_pkg::REG_DEADZONE: deadzone     <= cfg_data[swk_pkg::DZ_W-1:0];
        swk_pkg::REG_LENGTH:   length_ratio <= cfg_data;
        swk_pkg::REG_WIDTH:    width_ratio  <= cfg_data;
        swk_pkg::REG_SCALE:    speed_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the pipeline stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LEN-2:0], accept};
    end
  end

  // Stage A: capture the command.
  logic signed [CMD_W-1:0] a_x, a_y, a_rot;
  logic signed [ANG_W-1:0] a_hd;
  logic                    a_mode;
  logic [LANES-1:0][ANG_W-1:0] a_now;

  always_ff @(posedge clk) begin
    if (accept) begin
      a_x    <= strafe_cmd;
      a_y    <= forward_cmd;
      a_rot  <= rotate_cmd;
      a_hd   <= heading;
      a_mode <= mode;
      a_now  <= {br_now_angle, bl_now_angle, fr_now_angle, fl_now_angle};
    end
  end

  // Stage B: heading reduction, squares and rotation parts.
  logic signed [HD_W-1:0] hd_r1, hd_r2, hd_r3, hd_fold;
  logic                   hd_neg;
  logic signed [2*CMD_W-1:0] sq_x, sq_y;
  logic [2*swk_pkg::DZ_W-1:0] sq_dz;
  logic signed [CMD_W+swk_pkg::RATIO_W:0] lr_prod, wr_prod;
  swk_pkg::rot_vec_t rot_next;

  always_comb begin
    hd_r1 = HD_W'(a_hd);
    if (hd_r1 >= HD_FULL) begin
      hd_r1 = hd_r1 - HD_FULL;
    end else if (hd_r1 <= -HD_FULL) begin
      hd_r1 = hd_r1 + HD_FULL;
    end
    hd_r2 = (hd_r1 < 0) ? hd_r1 + HD_FULL : hd_r1;
    hd_r3 = (hd_r2 >= HD_HALF) ? hd_r2 - HD_FULL : hd_r2;
    hd_neg  = 1'b0;
    hd_fold = hd_r3;
    if (hd_r3 > HD_QUART) begin
      hd_neg  = 1'b1;
      hd_fold = hd_r3 - HD_HALF;
    end else if (hd_r3 < -HD_QUART) begin
      hd_neg  = 1'b1;
      hd_fold = hd_r3 + HD_HALF;
    end
    rot_next.cx = swk_pkg::ROT_W'(a_x) <<< 4;
    rot_next.cy = swk_pkg::ROT_W'(a_y) <<< 4;
    if (hd_neg) begin
      rot_next.cx = -rot_next.cx;
      rot_next.cy = -rot_next.cy;
    end
    rot_next.z = swk_pkg::Z_W'(hd_fold) <<< 8;
  end

  assign sq_x    = a_x * a_x;
  assign sq_y    = a_y * a_y;
  assign sq_dz   = deadzone * deadzone;
  assign lr_prod = a_rot * $signed({1'b0, length_ratio});
  assign wr_prod = a_rot * $signed({1'b0, width_ratio});

  swk_pkg::rot_vec_t b_rot;
  logic [2*CMD_W-2:0]         b_sqx, b_sqy;
  logic [2*swk_pkg::DZ_W-1:0] b_sqdz;
  logic                       b_rot_zero;
  side_t side_q [SIDE_DEPTH];

  always_ff @(posedge clk) begin
    b_rot        <= rot_next;
    b_sqx        <= sq_x[2*CMD_W-2:0];
    b_sqy        <= sq_y[2*CMD_W-2:0];
    b_sqdz       <= sq_dz;
    b_rot_zero   <= (a_rot == '0);
    side_q[0].x    <= a_x;
    side_q[0].y    <= a_y;
    side_q[0].mode <= a_mode;
    side_q[0].lr   <= lr_prod[CMD_W+swk_pkg::RATIO_W:swk_pkg::RATIO_W];
    side_q[0].wr   <= wr_prod[CMD_W+swk_pkg::RATIO_W:swk_pkg::RATIO_W];
    side_q[0].now  <= a_now;
  end

  // Side data delay line, aligned with the arithmetic stages.
  always_ff @(posedge clk) begin
    for (int k = 1; k < SIDE_DEPTH; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // Idle test, then its own delay line.
  logic [IDLE_DEPTH-1:0] idle_q;
  logic [2*CMD_W-1:0]    sq_sum;

  assign sq_sum = {1'b0, b_sqx} + {1'b0, b_sqy};

  always_ff @(posedge clk) begin
    idle_q <= {idle_q[IDLE_DEPTH-2:0],
                (sq_sum < (2*CMD_W)'(b_sqdz)) && b_rot_zero};
  end

  // Heading rotation CORDIC.
  swk_pkg::rot_vec_t rot_out;

  swk_rot_cordic u_rot (
    .clk  (clk),
    .din  (b_rot),
    .dout (rot_out)
  );

  // Stage D: CORDIC gain correction products.
  logic signed [swk_pkg::ROT_W+15:0] d_gx, d_gy;

  always_ff @(posedge clk) begin
    d_gx <= rot_out.cx * swk_pkg::INV_GAIN;
    d_gy <= rot_out.cy * swk_pkg::INV_GAIN;
  end

  // Stage E: round the rotated command and form the wheel vectors.
  logic signed [swk_pkg::ROT_W+15:0] gx_rnd, gy_rnd;
  logic signed [ANG_W-1:0]   xr, yr;
  logic signed [WHEEL_W-1:0] wa, wb, wc, wd;
  logic signed [WHEEL_W-1:0] e_vs [LANES];
  logic signed [WHEEL_W-1:0] e_vf [LANES];

  always_comb begin
    gx_rnd = d_gx + (swk_pkg::ROT_W+16)'(262144);
    gy_rnd = d_gy + (swk_pkg::ROT_W+16)'(262144);
    if (side_q[5].mode) begin
      xr = gx_rnd[35:19];
      yr = gy_rnd[35:19];
    end else begin
      xr = ANG_W'(side_q[5].x);
      yr = ANG_W'(side_q[5].y);
    end
    wa = WHEEL_W'(xr) - WHEEL_W'(side_q[5].lr);
    wb = WHEEL_W'(xr) + WHEEL_W'(side_q[5].lr);
    wc = WHEEL_W'(yr) - WHEEL_W'(side_q[5].wr);
    wd = WHEEL_W'(yr) + WHEEL_W'(side_q[5].wr);
  end

  // Wheel order: front-left, front-right, back-left, back-right.
  always_ff @(posedge clk) begin
    e_vs[0] <= wb;  e_vf[0] <= wc;
    e_vs[1] <= wb;  e_vf[1] <= wd;
    e_vs[2] <= wa;  e_vf[2] <= wd;
    e_vs[3] <= wa;  e_vf[3] <= wc;
  end

  // Per-wheel vectoring, angle rounding and magnitude.
  swk_pkg::vec_t vout [LANES];
  logic signed [ANG_W-1:0]             g_ang [LANES];
  logic signed [swk_pkg::VEC_W+15:0]   g_magp [LANES];
  logic [MAG_W-1:0]                    h_mag [LANES];
  logic signed [ANG_W-1:0]             h_ang [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [swk_pkg::Z_W-1:0]     z_rnd;
    logic signed [ANG_W-1:0]            ang_raw;
    logic signed [swk_pkg::VEC_W+15:0]  mag_rnd;

    swk_vec_cordic u_vec (
      .clk    (clk),
      .s_part (e_vs[l]),
      .f_part (e_vf[l]),
      .dout   (vout[l])
    );

    assign z_rnd   = vout[l].z + swk_pkg::Z_W'(128);
    assign ang_raw = z_rnd[swk_pkg::Z_W-1:8];
    assign mag_rnd = g_magp[l] + (swk_pkg::VEC_W+16)'(262144);

    // Stage G: clamp the angle, start the gain product.
    always_ff @(posedge clk) begin
      if (vout[l].zero) begin
        g_ang[l] <= '0;
      end else if (ang_raw > ANG_HALF) begin
        g_ang[l] <= ANG_HALF;
      end else if (ang_raw < -ANG_HALF) begin
        g_ang[l] <= -ANG_HALF;
      end else begin
        g_ang[l] <= ang_raw;
      end
      g_magp[l] <= vout[l].x * swk_pkg::INV_GAIN;
    end

    // Stage H: round the magnitude.
    always_ff @(posedge clk) begin
      h_mag[l] <= mag_rnd[MAG_W+18:19];
      h_ang[l] <= g_ang[l];
    end
  end

  // Stage I: largest wheel speed.
  logic [MAG_W-1:0] mx01, mx23, mx_all;
  logic [MAG_W-1:0] i_mx;
  mid_t             i_mid;
  mid_t             mid_q [swk_pkg::DIV_STAGES];

  assign mx01   = (h_mag[0] > h_mag[1]) ? h_mag[0] : h_mag[1];
  assign mx23   = (h_mag[2] > h_mag[3]) ? h_mag[2] : h_mag[3];
  assign mx_all = (mx01 > mx23) ? mx01 : mx23;

  always_ff @(posedge clk) begin
    i_mx       <= mx_all;
    i_mid.norm <= (mx_all > MAG_ONE);
    for (int l = 0; l < LANES; l++) begin
      i_mid.mag[l] <= h_mag[l];
      i_mid.ang[l] <= h_ang[l];
    end
  end

  // Hold magnitudes and angles while the divider runs.
  always_ff @(posedge clk) begin
    mid_q[0] <= i_mid;
    for (int k = 1; k < swk_pkg::DIV_STAGES; k++) begin
      mid_q[k] <= mid_q[k-1];
    end
  end

  // Normalizing dividers, stage K scaling and flip test.
  logic [QUO_W-1:0]        quo [LANES];
  logic [CMD_W-1:0]        k_spd [LANES];
  logic signed [ANG_W-1:0] k_ang [LANES];
  logic signed [ANG_W-1:0] k_now [LANES];
  logic                    k_flip [LANES];
  logic                    k_idle;
  mid_t                    mid_out;

  assign mid_out = mid_q[swk_pkg::DIV_STAGES-1];

  always_ff @(posedge clk) begin
    k_idle <= idle_q[IDLE_DEPTH-1];
  end

  for (genvar l = 0; l < LANES; l++) begin : g_fix
    logic [QUO_W-1:0]          sel;
    logic [QUO_W+swk_pkg::RATIO_W-1:0] scaled;
    logic signed [DIFF_W-1:0]  df1, df2, df3;
    logic signed [ANG_W-1:0]   adj;

    swk_div u_div (
      .clk (clk),
      .num (i_mid.mag[l]),
      .den (i_mx),
      .quo (quo[l])
    );

    assign sel    = mid_out.norm ? quo[l] : mid_out.mag[l][QUO_W-1:0];
    assign scaled = sel * speed_scale;

    // Shortest-turn difference folded into one half turn each way.
    always_comb begin
      df1 = DIFF_W'($signed(mid_out.ang[l])) - DIFF_W'($signed(side_q[SIDE_DEPTH-1].now[l]));
      if (df1 >= DF_TWO) begin
        df1 = df1 - DF_TWO;
      end else if (df1 >= DF_FULL) begin
        df1 = df1 - DF_FULL;
      end else if (df1 <= -DF_TWO) begin
        df1 = df1 + DF_TWO;
      end else if (df1 <= -DF_FULL) begin
        df1 = df1 + DF_FULL;
      end
      df2 = (df1 < 0) ? df1 + DF_FULL : df1;
      df3 = (df2 > DF_HALF) ? df2 - DF_FULL : df2;
    end

    always_ff @(posedge clk) begin
      k_spd[l]  <= scaled[QUO_W+swk_pkg::RATIO_W-1:swk_pkg::RATIO_W];
      k_ang[l]  <= $signed(mid_out.ang[l]);
      k_now[l]  <= $signed(side_q[SIDE_DEPTH-1].now[l]);
      k_flip[l] <= (df3 > DF_QUART) || (df3 < -DF_QUART);
    end

    assign adj = (k_ang[l] < 0) ? k_ang[l] + ANG_HALF : k_ang[l] - ANG_HALF;
  end

  // Stage L: apply the flip and the idle hold, register the result.
  always_ff @(posedge clk) begin
    fl_drive <= k_idle ? '0 : (k_flip[0] ? -$signed(k_spd[0]) : $signed(k_spd[0]));
    fr_drive <= k_idle ? '0 : (k_flip[1] ? -$signed(k_spd[1]) : $signed(k_spd[1]));
    bl_drive <= k_idle ? '0 : (k_flip[2] ? -$signed(k_spd[2]) : $signed(k_spd[2]));
    br_drive <= k_idle ? '0 : (k_flip[3] ? -$signed(k_spd[3]) : $signed(k_spd[3]));
    fl_steer <= k_idle ? k_now[0] : (k_flip[0] ? g_fix[0].adj : k_ang[0]);
    fr_steer <= k_idle ? k_now[1] : (k_flip[1] ? g_fix[1].adj : k_ang[1]);
    bl_steer <= k_idle ? k_now[2] : (k_flip[2] ? g_fix[2].adj : k_ang[2]);
    br_steer <= k_idle ? k_now[3] : (k_flip[3] ? g_fix[3].adj : k_ang[3]);
  end

endmodule

`default_nettype wire

@@ rtl/swk_checker.sv @@
// Port-level checks on the swerve wheel kinematics pipeline timing.
// Depends on swk_pkg; bound to swerve_wheel_kinematics at the end of this file.
`default_nettype none

module swk_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  start,
  input wire logic                                  busy,
  input wire logic signed [swk_pkg::CMD_W-1:0]      strafe_cmd,
  input wire logic signed [swk_pkg::CMD_W-1:0]      forward_cmd,
  input wire logic signed [swk_pkg::CMD_W-1:0]      rotate_cmd,
  input wire logic signed [swk_pkg::ANG_W-1:0]      heading,
  input wire logic                                  mode,
  input wire logic signed [swk_pkg::ANG_W-1:0]      fl_now_angle,
  input wire logic signed [swk_pkg::ANG_W-1:0]      fr_now_angle,
  input wire logic signed [swk_pkg::ANG_W-1:0]      bl_now_angle,
  input wire logic signed [swk_pkg::ANG_W-1:0]      br_now_angle,
  input wire logic                                  cfg_valid,
  input wire logic                                  cfg_ready,
  input wire logic [swk_pkg::CFG_IDX_W-1:0]         cfg_index,
  input wire logic [swk_pkg::CFG_DATA_W-1:0]        cfg_data,
  input wire logic                                  done,
  input wire logic signed [swk_pkg::CMD_W-1:0]      fl_drive,
  input wire logic signed [swk_pkg::CMD_W-1:0]      fr_drive,
  input wire logic signed [swk_pkg::CMD_W-1:0]      bl_drive,
  input wire logic signed [swk_pkg::CMD_W-1:0]      br_drive,
  input wire logic signed [swk_pkg::ANG_W-1:0]      fl_steer,
  input wire logic signed [swk_pkg::ANG_W-1:0]      fr_steer,
  input wire logic signed [swk_pkg::ANG_W-1:0]      bl_steer,
  input wire logic signed [swk_pkg::ANG_W-1:0]      br_steer
);

  // Every transfer is followed by a result strobe on done.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##22 done)
    else $error("command transfer without a result 22 cycles later");

  // No result appears without a matching transfer.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 22))
    else $error("result without a command transfer 22 cycles earlier");

  // Reset flushes the pipeline.
  a_reset_flush: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !done)
    else $error("result strobe right after reset");

endmodule

bind swerve_wheel_kinematics swk_checker u_swk_checker (.*);

`default_nettype wire
